[hw/rtl/xtea_pkg.sv]
// Package for the XTEA block cipher: payload and pipeline types, round constants,
// key reset values and the elaboration-time helpers for each round cell.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

   localparam int unsigned ROUNDS    = 32;
   localparam int unsigned NUM_CELLS = 2 * ROUNDS;
   localparam int unsigned NUM_KEYS  = 4;
   localparam int unsigned KEY_IDX_W = $clog2(NUM_KEYS);

   localparam logic [31:0] DELTA = 32'h9E3779B9;

   localparam logic [31:0] KEY_RESET [NUM_KEYS] = '{
      32'h0000FDA5, 32'h0000D54E, 32'h0000FC00, 32'h0000B55A
   };

   typedef enum logic {
      CMD_ENCIPHER = 1'b0,
      CMD_DECIPHER = 1'b1
   } command_type;

   typedef struct packed {
      command_type command;
      logic [31:0] word_first;
      logic [31:0] word_second;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] result_first;
      logic [31:0] result_second;
   } rsp_payload_type;

   typedef struct packed {
      logic        valid;
      command_type command;
      logic [31:0] first;
      logic [31:0] second;
   } stage_type;

   // Running sum seen by half-round idx of either direction.
   function automatic logic [31:0] stage_sum(input int unsigned idx, input logic dec);
      int unsigned n;
      logic        odd;
      logic [31:0] mult;
      n   = idx >> 1;
      odd = (idx & 1) == 1;
      if (!dec) begin
         mult = odd ? 32'(n + 1) : 32'(n);
      end else begin
         mult = odd ? 32'(ROUNDS - n - 1) : 32'(ROUNDS - n);
      end
      return DELTA * mult;
   endfunction

   // Key word chosen by half-round idx: low sum bits on the first-word update,
   // sum bits 12:11 on the second-word update.
   function automatic logic [KEY_IDX_W-1:0] stage_key_sel(input int unsigned idx,
                                                          input logic dec);
      logic [31:0] s;
      logic        odd;
      s   = stage_sum(idx, dec);
      odd = (idx & 1) == 1;
      return (odd ^ dec) ? s[12:11] : s[1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/xtea_round_cell.sv]
// One XTEA half-round cell: updates one word of the block from the other and
// registers the result. Depends on xtea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xtea_round_cell
   import xtea_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        odd_stage,
   input  wire logic [31:0] enc_term,
   input  wire logic [31:0] dec_term,
   input  wire stage_type   stage_in,
   output stage_type        stage_out
);

   stage_type   stage_ff;
   stage_type   stage_upd_in;
   logic        upd_second;
   logic [31:0] src_word;
   logic [31:0] dst_word;
   logic [31:0] mix;
   logic [31:0] key_term;
   logic [31:0] feistel;
   logic [31:0] new_word;

   // Encipher updates the first word on even cells, decipher on odd cells.
   assign upd_second = (stage_in.command == CMD_DECIPHER) ^ odd_stage;
   assign src_word   = upd_second ? stage_in.first  : stage_in.second;
   assign dst_word   = upd_second ? stage_in.second : stage_in.first;
   assign mix        = ((src_word << 4) ^ (src_word >> 5)) + src_word;
   assign key_term   = (stage_in.command == CMD_DECIPHER) ? dec_term : enc_term;
   assign feistel    = mix ^ key_term;
   assign new_word   = (stage_in.command == CMD_DECIPHER) ? dst_word - feistel
                                                          : dst_word + feistel;

   always_comb begin
      stage_upd_in         = stage_in;
      if (upd_second) begin
         stage_upd_in.second = new_word;
      end else begin
         stage_upd_in.first  = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_upd_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

[hw/rtl/xtea_out_skid.sv]
// Output register with a one-entry skid stage behind the round chain.
// Depends on xtea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xtea_out_skid
   import xtea_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire stage_type last_stage,
   output logic           advance,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff,  out_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff,  skid_data_in;
   logic            out_free;
   rsp_payload_type last_data;

   assign advance   = !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign last_data = '{result_first: last_stage.first, result_second: last_stage.second};

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // drain the skid first; the chain is frozen meanwhile
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = last_stage.valid;
            out_data_in  = last_data;
         end
      end else if (last_stage.valid && advance) begin
         skid_valid_in = 1'b1;
         skid_data_in  = last_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

`default_nettype wire

[hw/rtl/xtea_block_cipher.sv]
// XTEA cipher top level: 2*ROUNDS half-round cells (64 by default) and an output register.
// Each half-round cell registers its result, and the output register follows the last one.
// Throughput: one block per cycle; the chain freezes only while the skid entry is full.
// Reset (synchronous, active high) empties the chain and skid and loads the default key.
// Depends on xtea_pkg, xtea_round_cell and xtea_out_skid.
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_cipher
   import xtea_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_payload_type      req_payload,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_payload_type           rsp_payload,
   // key registers
   input  wire logic                 csr_wr_en,
   input  wire logic [KEY_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   logic [31:0] key_ff [NUM_KEYS];
   logic [31:0] key_in [NUM_KEYS];
   logic        advance;
   stage_type   chain [NUM_CELLS+1];

   // Key file: it must be written only while no transfer is in flight (the block does not
   // enforce this), so the round terms below may be formed straight from it.
   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_in[k] = key_ff[k];
      end
      if (csr_wr_en) begin
         key_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_ff[k] <= KEY_RESET[k];
         end
      end else begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_ff[k] <= key_in[k];
         end
      end
   end

   // Hold the input off only while the skid entry holds a result.
   assign req_stall = !advance;

   always_comb begin
      chain[0].valid   = req_valid && !req_stall;
      chain[0].command = req_payload.command;
      chain[0].first   = req_payload.word_first;
      chain[0].second  = req_payload.word_second;
   end

   // Each cell carries fixed sums for both directions; add the selected key
   // word here so the cell only mixes, XORs and adds or subtracts.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      localparam logic [31:0]          ENC_SUM = stage_sum(i, 1'b0);
      localparam logic [31:0]          DEC_SUM = stage_sum(i, 1'b1);
      localparam logic [KEY_IDX_W-1:0] ENC_SEL = stage_key_sel(i, 1'b0);
      localparam logic [KEY_IDX_W-1:0] DEC_SEL = stage_key_sel(i, 1'b1);
      localparam logic                 ODD     = (i % 2) == 1;

      logic [31:0] enc_term;
      logic [31:0] dec_term;

      assign enc_term = ENC_SUM + key_ff[ENC_SEL];
      assign dec_term = DEC_SUM + key_ff[DEC_SEL];

      xtea_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .odd_stage (ODD),
         .enc_term  (enc_term),
         .dec_term  (dec_term),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // Output register plus skid: a stalled result lets the chain advance once
   // more to park the next one, then freezes it until the skid entry drains.
   xtea_out_skid u_out (
      .clock       (clock),
      .reset       (reset),
      .last_stage  (chain[NUM_CELLS]),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[tb/xtea_block_cipher_test.sv]
// Self-checking testbench for xtea_block_cipher: drives 64-bit blocks under a range of keys,
// predicts each result with a local XTEA model and checks every result transfer in order.
// Depends on xtea_pkg and xtea_block_cipher.
`timescale 1ns / 1ps

module xtea_block_cipher_test;
   import xtea_pkg::*;

   localparam int unsigned CLOCK_PERIOD = 8;
   localparam int unsigned PIPE_CYCLES  = 2 * ROUNDS;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_wr_en   = 1'b0;
   logic [KEY_IDX_W-1:0] csr_index   = '0;
   logic [31:0]          csr_wdata   = '0;

   // Local copy of the key registers, kept in step with every CSR write.
   logic [31:0] key_words [NUM_KEYS];

   // Ciphertext/plaintext blocks still owed by the DUT, oldest first.
   rsp_payload_type expected_blocks [$];

   // Sender and receiver both insert gap bursts while this is set.
   bit gaps_on = 1'b0;

   int unsigned mismatches   = 0;
   int unsigned enciphered   = 0;
   int unsigned deciphered   = 0;
   int unsigned checked      = 0;
   int unsigned keys_loaded  = 0;
   int unsigned stall_left   = 0;

   xtea_block_cipher DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   // XTEA over ROUNDS round pairs with the current key copy. Decipher starts from
   // DELTA * ROUNDS so that it undoes encipher for any round count.
   function automatic rsp_payload_type xtea_transform(input req_payload_type blk);
      logic [31:0]     v0;
      logic [31:0]     v1;
      logic [31:0]     sum;
      rsp_payload_type res;
      v0 = blk.word_first;
      v1 = blk.word_second;
      if (blk.command == CMD_ENCIPHER) begin
         sum = '0;
         for (int n = 0; n < ROUNDS; n++) begin
            v0  = v0 + ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key_words[sum[1:0]]));
            sum = sum + DELTA;
            v1  = v1 + ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key_words[sum[12:11]]));
         end
      end else begin
         sum = DELTA * 32'(ROUNDS);
         for (int n = 0; n < ROUNDS; n++) begin
            v1  = v1 - ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key_words[sum[12:11]]));
            sum = sum - DELTA;
            v0  = v0 - ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key_words[sum[1:0]]));
         end
      end
      res.result_first  = v0;
      res.result_second = v1;
      return res;
   endfunction

   // Mostly uniform words, with the all-zero and all-one words thrown in often.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Result side: check each transfer against the oldest expectation, then decide the
   // stall for the next cycle. Values read here are the ones sampled at this edge.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result transfer: expected none, got %h_%h",
                     $time, rsp_payload.result_first, rsp_payload.result_second);
            mismatches++;
         end else begin
            want = expected_blocks.pop_front();
            checked++;
            if (rsp_payload.result_first !== want.result_first) begin
               $display("%0t: result_first mismatch: expected %h, got %h",
                        $time, want.result_first, rsp_payload.result_first);
               mismatches++;
            end
            if (rsp_payload.result_second !== want.result_second) begin
               $display("%0t: result_second mismatch: expected %h, got %h",
                        $time, want.result_second, rsp_payload.result_second);
               mismatches++;
            end
         end
      end
      // Stall in bursts while gaps are enabled; otherwise drain freely.
      if (stall_left > 0) begin
         stall_left--;
      end else if (!reset && gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 5);
      end
      rsp_stall <= (stall_left > 0);
   end

   // Present one block and hold it until the transfer happens; queue its prediction.
   // req_valid is left high so that the next block can follow back to back.
   task automatic send_block(input command_type cmd, input logic [31:0] w0,
                             input logic [31:0] w1, output rsp_payload_type predicted);
      req_payload_type blk;
      blk.command     = cmd;
      blk.word_first  = w0;
      blk.word_second = w1;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= blk;
      do @(posedge clock); while (req_stall);
      predicted = xtea_transform(blk);
      expected_blocks.push_back(predicted);
      if (cmd == CMD_ENCIPHER) enciphered++;
      else deciphered++;
   endtask

   // Drop valid and hold off until every outstanding result has come back.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   // Write all four key words on consecutive edges. Call only with the pipeline empty.
   task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3);
      logic [31:0] words [NUM_KEYS];
      words = '{k0, k1, k2, k3};
      for (int i = 0; i < NUM_KEYS; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= KEY_IDX_W'(i);
         csr_wdata <= words[i];
         @(posedge clock);
         key_words[i] = words[i];
      end
      csr_wr_en <= 1'b0;
      keys_loaded++;
   endtask

   // Corner blocks in both directions under the reset key.
   task automatic test_reset_key_corners();
      logic [31:0]     firsts  [7];
      logic [31:0]     seconds [7];
      rsp_payload_type unused;
      firsts  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'hAAAA_AAAA, 32'h8000_0000, 32'h0000_0001};
      seconds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h5555_5555, 32'h0000_0001, 32'h8000_0000};
      gaps_on = 1'b1;
      for (int i = 0; i < 7; i++) begin
         send_block(CMD_ENCIPHER, firsts[i], seconds[i], unused);
         send_block(CMD_DECIPHER, firsts[i], seconds[i], unused);
      end
      drain_pipeline();
   endtask

   // Extreme keys: all zeros and all ones, each with zero and all-one blocks.
   task automatic test_extreme_keys();
      rsp_payload_type unused;
      load_key('0, '0, '0, '0);
      send_block(CMD_ENCIPHER, '0, '0, unused);
      send_block(CMD_DECIPHER, '1, '1, unused);
      drain_pipeline();
      load_key('1, '1, '1, '1);
      send_block(CMD_ENCIPHER, '1, '1, unused);
      send_block(CMD_DECIPHER, '0, '0, unused);
      drain_pipeline();
   endtask

   // Random keys, each followed by a burst of traffic: mostly encipher/decipher round
   // trips on random data, the rest single blocks with a random direction.
   task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
      rsp_payload_type forward;
      rsp_payload_type unused;
      int unsigned     sent;
      command_type     cmd;
      for (int p = 0; p < phases; p++) begin
         load_key($urandom, $urandom, $urandom, $urandom);
         sent = 0;
         while (sent < per_phase) begin
            if (sent % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            cmd = command_type'($urandom_range(0, 1));
            if ($urandom_range(0, 2) != 0) begin
               send_block(cmd, pick_word(), pick_word(), forward);
               send_block(cmd == CMD_ENCIPHER ? CMD_DECIPHER : CMD_ENCIPHER,
                          forward.result_first, forward.result_second, unused);
               sent += 2;
            end else begin
               send_block(cmd, pick_word(), pick_word(), unused);
               sent++;
            end
            // Around mid-phase, let the whole pipeline empty before carrying on.
            if (sent == per_phase / 2 || sent == per_phase / 2 + 1) drain_pipeline();
         end
         drain_pipeline();
      end
   endtask

   // Closing stretch at full rate: no gaps on either side.
   task automatic test_full_rate(input int unsigned count);
      rsp_payload_type unused;
      gaps_on = 1'b0;
      load_key($urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < count; i++) begin
         send_block(command_type'($urandom_range(0, 1)), $urandom, $urandom, unused);
      end
      drain_pipeline();
   endtask

   initial begin
      key_words = KEY_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_key_corners();
      test_extreme_keys();
      test_random_traffic(5, 240);
      test_full_rate(250);

      // Give the chain its full depth once more to catch any stray transfer.
      repeat (PIPE_CYCLES + 8) @(posedge clock);
      $display("Covered %0d encipher and %0d decipher blocks under %0d key loads;",
               enciphered, deciphered, keys_loaded);
      $display("%0d results compared, %0d mismatches.", checked, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #(64'd2_000_000);
      $display("Timed out with %0d results still outstanding.", expected_blocks.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
